// File: rtl/core/wrs_pkg.sv
// Shared widths, request/status codes and types for the weighted random selector.
// No dependencies; used by every module in rtl/core.
package wrs_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int W_W     = 16;   // weight width
    localparam int R_W     = 31;   // random value width
    localparam int SUM_W   = 20;   // weight sum width, wraps
    localparam int TOT_W   = SUM_W + 1; // running total: reduced value plus one weight
    localparam int IDX_W   = 4;    // selected index width
    localparam int ST_W    = 2;    // status width
    localparam int DCNT_W  = $clog2(R_W + 1);

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_SELECT = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // divider status back to the controller
    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] rem;
    } t_div_stat;

endpackage

// File: rtl/core/weighted_random_selector.sv
// Weighted random selector: weight table in a synchronous RAM, sum/count registers,
// a serial remainder unit and a table walk. Depends on wrs_pkg, wrs_wmem, wrs_div.
//
// Usage:
//   Request channel i_valid/o_ready carries i_req_type, i_weight_value, i_random_value.
//   Append (REQ_APPEND) stores a weight at the end of the table and adds it to
//   the 20-bit running sum; a full table drops the weight and reports ST_FULL.
//   Select (REQ_SELECT) reduces i_random_value modulo the weight sum (modulo the
//   entry count when the sum is zero) and returns the first index whose running
//   total exceeds it, else index 0. Empty table reports ST_EMPTY.
//   Result channel o_valid/i_ready carries o_selected_index, o_status; one result
//   per request, in order.
// Sequence:
//   Append, and select on an empty table: the result goes to the finish state, then
//   loads the output register. Select otherwise: the one-bit-per-cycle remainder
//   unit runs over all R_W dividend bits and hands its remainder to the walk, which
//   does one registered RAM read per entry walked, then the result loads the output
//   register. One request is in flight at a time; o_ready is high only when idle.
// Reset (synchronous, active low) empties the table and clears the sum.
// Stalls: the output register holds a result while i_ready is low; a new request
// may be accepted meanwhile, and its result waits in the finish state.
module weighted_random_selector #(
    parameter int MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_req_type,
    input  logic [wrs_pkg::W_W-1:0]   i_weight_value,
    input  logic [wrs_pkg::R_W-1:0]   i_random_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [wrs_pkg::IDX_W-1:0] o_selected_index,
    output logic [wrs_pkg::ST_W-1:0]  o_status
);
    import wrs_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);       // table address
    localparam int CW = $clog2(MAX_ENTRIES + 1);   // entry count

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;

    // walk pipeline
    logic [CW-1:0]    r_rd_idx, n_rd_idx;
    logic             r_pend, n_pend;
    logic [AW-1:0]    r_pend_idx, n_pend_idx;
    logic [TOT_W-1:0] r_total, n_total;
    logic [SUM_W-1:0] r_red, n_red;

    // pending result and output register
    logic [AW-1:0]    r_res_idx, n_res_idx;
    logic [ST_W-1:0]  r_res_st, n_res_st;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [ST_W-1:0]  r_out_st;

    logic             accept;
    logic             out_load;
    logic             rd_issue;
    logic             mem_we;
    logic [W_W-1:0]   rdata;
    logic [TOT_W-1:0] walk_sum;
    logic [AW+IDX_W-1:0] res_idx_ext;
    logic             div_start;
    logic [SUM_W-1:0] div_divisor;
    t_div_stat        div_stat;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_ready);
    assign rd_issue = (r_state == S_WALK) && (r_rd_idx < r_count);
    assign mem_we   = accept && (i_req_type == REQ_APPEND)
                      && (r_count < CW'(MAX_ENTRIES));
    assign walk_sum = r_total + {{(TOT_W-W_W){1'b0}}, rdata};

    // zero sum: reduce modulo the entry count instead
    assign div_start   = accept && (i_req_type == REQ_SELECT) && (r_count != '0);
    assign div_divisor = (r_sum != '0) ? r_sum : {{(SUM_W-CW){1'b0}}, r_count};

    // index keeps its low bits only
    assign res_idx_ext = {{IDX_W{1'b0}}, r_res_idx};

    wrs_wmem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_weight_value),
        .i_re    (rd_issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rdata)
    );

    wrs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_random_value),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat)
    );

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_sum      = r_sum;
        n_rd_idx   = r_rd_idx;
        n_pend     = 1'b0;
        n_pend_idx = r_rd_idx[AW-1:0];
        n_total    = r_total;
        n_red      = r_red;
        n_res_idx  = r_res_idx;
        n_res_st   = r_res_st;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_idx = '0;
                    n_res_st  = ST_OK;
                    if (i_req_type == REQ_APPEND) begin
                        n_state = S_FIN;
                        if (mem_we) begin
                            n_count = r_count + CW'(1);
                            n_sum   = r_sum + {{(SUM_W-W_W){1'b0}}, i_weight_value};
                        end else begin
                            n_res_st = ST_FULL;
                        end
                    end else if (r_count == '0) begin
                        n_state  = S_FIN;
                        n_res_st = ST_EMPTY;
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_red    = div_stat.rem;
                    n_total  = '0;
                    n_rd_idx = '0;
                    n_state  = S_WALK;
                end
            end
            S_WALK: begin
                n_pend = rd_issue;
                if (rd_issue) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                if (r_pend) begin
                    n_total = walk_sum;
                    if ({1'b0, r_red} < walk_sum) begin
                        n_res_idx = r_pend_idx;
                        n_state   = S_FIN;
                        n_pend    = 1'b0;
                    end else if (!rd_issue) begin
                        n_res_idx = '0;
                        n_state   = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_pend_idx <= n_pend_idx;
        r_total    <= n_total;
        r_red      <= n_red;
        r_res_idx  <= n_res_idx;
        r_res_st   <= n_res_st;
        if (out_load) begin
            r_out_idx <= res_idx_ext[IDX_W-1:0];
            r_out_st  <= r_res_st;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_selected_index = r_out_idx;
    assign o_status         = r_out_st;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond table depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_rd_idx <= r_count))
        else $error("walk read index beyond entry count");

    a_pend_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (CW'(r_pend_idx) < r_count))
        else $error("walk evaluates an unwritten entry");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("remainder finished outside select");

    a_err_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_selected_index == '0))
        else $error("nonzero index on error status");
`endif

endmodule

// File: rtl/core/wrs_wmem.sv
// Weight table storage: one write port, one read port, registered read data.
// Depends on wrs_pkg.
module wrs_wmem #(
    parameter int DEPTH = wrs_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [wrs_pkg::W_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic [wrs_pkg::W_W-1:0] o_rdata
);
    import wrs_pkg::*;

    logic [W_W-1:0] r_mem [DEPTH];
    logic [W_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/wrs_div.sv
// Restoring remainder unit: one dividend bit per cycle, over all R_W dividend bits.
// Depends on wrs_pkg. Divisor must be nonzero.
module wrs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wrs_pkg::R_W-1:0]   i_dividend,
    input  logic [wrs_pkg::SUM_W-1:0] i_divisor,
    output wrs_pkg::t_div_stat        o_stat
);
    import wrs_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [TOT_W-1:0]  r_rem, n_rem;
    logic [R_W-1:0]    r_dvd, n_dvd;
    logic [TOT_W-1:0]  r_dsr, n_dsr;
    logic [TOT_W-1:0]  trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        trial  = {r_rem[SUM_W-1:0], r_dvd[R_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(R_W);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = {1'b0, i_divisor};
        end else if (r_busy) begin
            n_rem = (trial >= r_dsr) ? (trial - r_dsr) : trial;
            n_dvd = {r_dvd[R_W-2:0], 1'b0};
            n_cnt = r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
    end

    assign o_stat.done = r_done;
    assign o_stat.rem  = r_rem[SUM_W-1:0];

endmodule
